>>> rtl/tbpc_pkg.sv
// Types, event codes and the per-tracker update function for the two-button
// press classifier. No dependencies.
package tbpc_pkg;

    localparam int TIME_W  = 32;
    localparam int THR_W   = 16;
    localparam int EVENT_W = 3;
    localparam int CFG_IDX_W = 8;

    localparam logic [EVENT_W-1:0] EV_NONE        = 3'd0;
    localparam logic [EVENT_W-1:0] EV_COMBO_SHORT = 3'd1;
    localparam logic [EVENT_W-1:0] EV_COMBO_LONG  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_A_SHORT     = 3'd3;
    localparam logic [EVENT_W-1:0] EV_A_LONG      = 3'd4;
    localparam logic [EVENT_W-1:0] EV_B_SHORT     = 3'd5;
    localparam logic [EVENT_W-1:0] EV_B_LONG      = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_LONG = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMBO_LONG  = 8'd1;

    localparam logic [THR_W-1:0] SINGLE_LONG_RESET = 16'd1000;
    localparam logic [THR_W-1:0] COMBO_LONG_RESET  = 16'd3000;

    typedef struct packed {
        logic              level;
        logic [TIME_W-1:0] start;
        logic              long_done;
    } trk_t;

    typedef struct packed {
        logic [EVENT_W-1:0] ev;
        trk_t               nxt;
    } tick_t;

    function automatic tick_t trk_tick(
        input trk_t               cur,
        input logic               now,
        input logic [TIME_W-1:0]  t,
        input logic [THR_W-1:0]   thr,
        input logic [EVENT_W-1:0] short_code,
        input logic [EVENT_W-1:0] long_code
    );
        tick_t             r;
        logic              rise;
        logic              flag;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] held;
        rise  = now && !cur.level;
        start = rise ? t : cur.start;
        flag  = rise ? 1'b0 : cur.long_done;
        held  = t - start;
        r.ev  = EV_NONE;
        r.nxt.level     = now;
        r.nxt.start     = start;
        r.nxt.long_done = flag;
        if (!now && cur.level && !flag) begin
            r.ev = short_code;
        end
        if (now && !flag && (held >= {{(TIME_W-THR_W){1'b0}}, thr})) begin
            r.ev = long_code;
            r.nxt.long_done = 1'b1;
        end
        return r;
    endfunction

endpackage

>>> rtl/two_button_press_classifier_top.sv
// Two-button press classifier: one event code per poll of buttons A and B.
// Depends on tbpc_pkg (types, codes, tracker update).
//
//  channel | handshake         | beat
//  s_      | s_valid/s_ready   | button_a_level, button_b_level, time_ms
//  m_      | m_valid/m_ready   | event_code
//  cfg_    | cfg_valid/cfg_ready | cfg_index, cfg_data (0 single_long_ms, 1 combo_long_ms)
//
// One poll per cycle sustained while m_ is not stalled; m_valid rises once an accepted
// s_ beat has passed the input register, then the tracker update into the result register.
// Tracker state advances in the same cycle the result register loads.
// A stalled m_ holds the result; s_ keeps accepting while the input register
// can drain. cfg_ready is always high. Reset is synchronous, active low.
module two_button_press_classifier_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_button_a_level,
    input  logic                         s_button_b_level,
    input  logic [tbpc_pkg::TIME_W-1:0]  s_time_ms,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tbpc_pkg::EVENT_W-1:0] m_event_code,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tbpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tbpc_pkg::THR_W-1:0]   cfg_data
);
    import tbpc_pkg::*;

    logic               in_valid_reg;
    logic               a_reg;
    logic               b_reg;
    logic [TIME_W-1:0]  t_reg;
    logic               out_valid_reg;
    logic [EVENT_W-1:0] event_reg;
    logic [THR_W-1:0]   single_long_reg;
    logic [THR_W-1:0]   combo_long_reg;
    trk_t               combo_reg, a_trk_reg, b_trk_reg;
    trk_t               combo_next, a_trk_next, b_trk_next;
    logic [EVENT_W-1:0] event_next;
    tick_t              combo_tk, a_tk, b_tk;
    logic               ab;
    logic               advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_event_code = event_reg;
    assign cfg_ready = 1'b1;

    assign ab = a_reg && b_reg;

    always_comb begin
        combo_tk   = trk_tick(combo_reg, ab, t_reg, combo_long_reg,
                              EV_COMBO_SHORT, EV_COMBO_LONG);
        a_tk       = trk_tick(a_trk_reg, a_reg, t_reg, single_long_reg,
                              EV_A_SHORT, EV_A_LONG);
        b_tk       = trk_tick(b_trk_reg, b_reg, t_reg, single_long_reg,
                              EV_B_SHORT, EV_B_LONG);
        combo_next = combo_tk.nxt;
        a_trk_next = a_trk_reg;
        b_trk_next = b_trk_reg;
        event_next = combo_tk.ev;
        if (combo_tk.ev == EV_NONE) begin
            if (!ab) begin
                a_trk_next = a_tk.nxt;
                event_next = a_tk.ev;
                if (a_tk.ev == EV_NONE) begin
                    b_trk_next = b_tk.nxt;
                    event_next = b_tk.ev;
                end
            end else begin
                a_trk_next.level = a_reg;
                b_trk_next.level = b_reg;
                if (!a_reg) begin
                    a_trk_next.long_done = 1'b0;
                end
                if (!b_reg) begin
                    b_trk_next.long_done = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            single_long_reg <= SINGLE_LONG_RESET;
            combo_long_reg  <= COMBO_LONG_RESET;
            combo_reg       <= '0;
            a_trk_reg       <= '0;
            b_trk_reg       <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                combo_reg     <= combo_next;
                a_trk_reg     <= a_trk_next;
                b_trk_reg     <= b_trk_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SINGLE_LONG: single_long_reg <= cfg_data;
                    CFG_COMBO_LONG:  combo_long_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_reg <= s_button_a_level;
            b_reg <= s_button_b_level;
            t_reg <= s_time_ms;
        end
        if (advance) begin
            event_reg <= event_next;
        end
    end

endmodule
